@@ src/scrsc_pkg.sv @@
// Shared decode codes, constants and types for the single-cycle RISC subset core.
package scrsc_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned IDX_W     = 30;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW    = $clog2(REG_COUNT);

  localparam logic [XLEN-1:0] TEXT_BASE_RESET = 32'h0040_0000;

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_J     = 6'b000010;
  localparam logic [5:0] OP_BEQ   = 6'b000100;
  localparam logic [5:0] OP_ADDI  = 6'b001000;
  localparam logic [5:0] OP_ADDIU = 6'b001001;

  // R-type function codes
  localparam logic [5:0] FN_ADD  = 6'b100000;
  localparam logic [5:0] FN_ADDU = 6'b100001;
  localparam logic [5:0] FN_SUB  = 6'b100010;
  localparam logic [5:0] FN_MULT = 6'b011000;
  localparam logic [5:0] FN_MFLO = 6'b010010;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic              reg_write;
    logic [REG_AW-1:0] dest_reg;
    logic [XLEN-1:0]   dest_value;
    logic              lo_written;
    logic [XLEN-1:0]   lo_value;
    logic [IDX_W-1:0]  next_index;
  } exec_res_t;

endpackage

@@ src/scrsc_regfile.sv @@
// General register file: 32 x 32 memory, two registered reads, write bypass, valid bits.
module scrsc_regfile (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [scrsc_pkg::REG_AW-1:0]  rs_addr,
  input  logic [scrsc_pkg::REG_AW-1:0]  rt_addr,
  input  scrsc_pkg::rf_wr_t             wr,
  output logic [scrsc_pkg::XLEN-1:0]    rs_data,
  output logic [scrsc_pkg::XLEN-1:0]    rt_data
);

  logic [scrsc_pkg::XLEN-1:0]      mem [scrsc_pkg::REG_COUNT];
  logic [scrsc_pkg::REG_COUNT-1:0] written;

  logic [scrsc_pkg::XLEN-1:0] ram_a, ram_b, fwd_val;
  logic                       fwd_a, fwd_b, vld_a, vld_b;

  // entries not yet written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read at accept; a write landing on the same edge is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ram_a   <= mem[rs_addr];
      ram_b   <= mem[rt_addr];
      vld_a   <= written[rs_addr];
      vld_b   <= written[rt_addr];
      fwd_a   <= wr.en && (wr.addr == rs_addr);
      fwd_b   <= wr.en && (wr.addr == rt_addr);
      fwd_val <= wr.data;
    end
  end

  assign rs_data = fwd_a ? fwd_val : (vld_a ? ram_a : '0);
  assign rt_data = fwd_b ? fwd_val : (vld_b ? ram_b : '0);

endmodule

@@ src/scrsc_exec.sv @@
// Decode, ALU, multiplier and next-index logic for one instruction.
module scrsc_exec (
  input  logic [31:0]                     instr_word,
  input  logic [scrsc_pkg::XLEN-1:0]      rs_val,
  input  logic [scrsc_pkg::XLEN-1:0]      rt_val,
  input  logic [scrsc_pkg::XLEN-1:0]      lo_val,
  input  logic [scrsc_pkg::IDX_W-1:0]     pc_index,
  input  logic [scrsc_pkg::XLEN-1:0]      text_base,
  output scrsc_pkg::exec_res_t            res
);

  logic [5:0]                  op, fn;
  logic [scrsc_pkg::REG_AW-1:0] rt, rd;
  logic [scrsc_pkg::XLEN-1:0]  imm, tgt, jdiff, val;
  logic [63:0]                 prod;
  logic [scrsc_pkg::IDX_W-1:0] seq_idx;
  logic                        wr;
  logic [scrsc_pkg::REG_AW-1:0] dst;

  assign op      = instr_word[31:26];
  assign rt      = instr_word[20:16];
  assign rd      = instr_word[15:11];
  assign fn      = instr_word[5:0];
  assign imm     = {{16{instr_word[15]}}, instr_word[15:0]};
  assign tgt     = {instr_word[25:0], 2'b00};
  assign jdiff   = tgt - text_base;
  assign prod    = rs_val * rt_val;
  assign seq_idx = pc_index + 30'd1;

  always_comb begin
    wr             = 1'b0;
    dst            = '0;
    val            = '0;
    res.lo_written = 1'b0;
    res.lo_value   = prod[scrsc_pkg::XLEN-1:0];
    res.next_index = seq_idx;
    case (op)
      scrsc_pkg::OP_RTYPE: begin
        case (fn)
          scrsc_pkg::FN_ADD, scrsc_pkg::FN_ADDU: begin
            wr = 1'b1; dst = rd; val = rs_val + rt_val;
          end
          scrsc_pkg::FN_SUB: begin
            wr = 1'b1; dst = rd; val = rs_val - rt_val;
          end
          scrsc_pkg::FN_MULT: begin
            res.lo_written = 1'b1;
          end
          scrsc_pkg::FN_MFLO: begin
            wr = 1'b1; dst = rd; val = lo_val;
          end
          default: ;
        endcase
      end
      scrsc_pkg::OP_ADDI, scrsc_pkg::OP_ADDIU: begin
        wr = 1'b1; dst = rt; val = rs_val + imm;
      end
      scrsc_pkg::OP_J: begin
        res.next_index = jdiff[31:2];
      end
      scrsc_pkg::OP_BEQ: begin
        if (rs_val == rt_val) begin
          res.next_index = seq_idx + imm[scrsc_pkg::IDX_W-1:0];
        end
      end
      default: ;
    endcase
    // register zero is hardwired; a dropped write reports all zero
    if (wr && (dst != '0)) begin
      res.reg_write  = 1'b1;
      res.dest_reg   = dst;
      res.dest_value = val;
    end else begin
      res.reg_write  = 1'b0;
      res.dest_reg   = '0;
      res.dest_value = '0;
    end
  end

endmodule

@@ src/single_cycle_risc_subset_core.sv @@
// A request moves from the decode stage into the result register. Throughput: one
// instruction per cycle while out_stall is low; the register file is read at accept and
// the instruction executes and writes back as it moves into the result register.
// Reset (rst, synchronous): registers read as zero, LO and the instruction index clear
// to zero, text_base returns to 0x00400000, both pipeline stages empty.
module single_cycle_risc_subset_core (
  input  logic               clk,
  input  logic               rst,
  // instruction request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        instr_word,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [29:0]        executed_index,
  output logic               reg_write,
  output logic [4:0]         dest_reg,
  output logic signed [31:0] dest_value,
  output logic               lo_written,
  output logic [29:0]        next_index,
  // configuration
  input  logic               text_base_we,
  input  logic [31:0]        text_base
);

  // decode stage: instruction word plus register operands read at accept
  logic        s1_valid;
  logic [31:0] s1_word;

  logic [scrsc_pkg::XLEN-1:0]  text_base_reg;
  logic [scrsc_pkg::XLEN-1:0]  lo_reg;
  logic [scrsc_pkg::IDX_W-1:0] pc_index;

  logic [scrsc_pkg::XLEN-1:0]  rs_val, rt_val;
  scrsc_pkg::exec_res_t        res;
  scrsc_pkg::rf_wr_t           rf_wr;

  logic in_accept, move;

  // the decode stage retires whenever the result register is free or being drained
  assign move      = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !move;
  assign in_accept = in_valid && !in_stall;

  // architectural state is updated as the instruction retires
  assign rf_wr.en   = move && res.reg_write;
  assign rf_wr.addr = res.dest_reg;
  assign rf_wr.data = res.dest_value;

  scrsc_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rs_addr (instr_word[25:21]),
    .rt_addr (instr_word[20:16]),
    .wr      (rf_wr),
    .rs_data (rs_val),
    .rt_data (rt_val)
  );

  scrsc_exec u_exec (
    .instr_word (s1_word),
    .rs_val     (rs_val),
    .rt_val     (rt_val),
    .lo_val     (lo_reg),
    .pc_index   (pc_index),
    .text_base  (text_base_reg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_base_reg <= scrsc_pkg::TEXT_BASE_RESET;
    end else if (text_base_we) begin
      text_base_reg <= text_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word <= instr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_index <= '0;
      lo_reg   <= '0;
    end else if (move) begin
      pc_index <= res.next_index;
      if (res.lo_written) begin
        lo_reg <= res.lo_value;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= move || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      executed_index <= pc_index;
      reg_write      <= res.reg_write;
      dest_reg       <= res.dest_reg;
      dest_value     <= res.dest_value;
      lo_written     <= res.lo_written;
      next_index     <= res.next_index;
    end
  end

endmodule
